// File: src/sact_pkg.sv
// package: shared constants and types of the cache tag lookup
package sact_pkg;
    localparam int MAX_SETS_DEF   = 256;
    localparam int MAX_WAYS_DEF   = 8;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int TAG_W          = 32;
    localparam int SET_OUT_W      = 8;
    localparam int RANK_W         = 3;
    localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
    localparam logic [15:0] LFSR_RESET = 16'd44257;

    localparam logic [2:0] CFG_WAY_BITS    = 3'd0;
    localparam logic [2:0] CFG_SET_BITS    = 3'd1;
    localparam logic [2:0] CFG_OFFSET_BITS = 3'd2;
    localparam logic [2:0] CFG_POLICY      = 3'd3;
    localparam logic [2:0] CFG_WT          = 3'd4;

    localparam logic [1:0] POL_FIFO       = 2'd0;
    localparam logic [1:0] POL_LRU        = 2'd1;
    localparam logic [1:0] POL_RANDOM     = 2'd2;
    localparam logic [1:0] POL_RANDOM_ALT = 2'd3;

    typedef struct packed {
        logic [1:0] way_bits;
        logic [3:0] set_bits;
        logic [3:0] offset_bits;
        logic [1:0] policy;
        logic       write_through;
    } cfg_t;

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[15:1]};
    endfunction
endpackage

// File: src/sact_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: src/sact_front.sv
// front end: accepts accesses, splits address into set and tag, queues them
module sact_front
    import sact_pkg::*;
#(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_t                        cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [ADDR_WIDTH-1:0]       s_address,
    output logic                        q_valid,
    input  logic                        q_pop,
    output logic                        q_func,
    output logic [$clog2(MAX_SETS)-1:0] q_set,
    output logic [SET_OUT_W-1:0]        q_set_raw,
    output logic [TAG_W-1:0]            q_tag
);
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int EW = 1 + SW + SET_OUT_W + TAG_W;
    logic [EW-1:0] q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    logic [3:0] sb;
    logic [ADDR_WIDTH-1:0] sh;
    logic [7:0] set_raw;
    logic [TAG_W-1:0] tag;
    logic [ADDR_WIDTH-1:0] tsh;
    logic push;

    assign sb = (cfg.set_bits > 4'd8) ? 4'd8 : cfg.set_bits;
    assign sh = s_address >> cfg.offset_bits;
    assign set_raw = sh[7:0] & 8'((9'd1 << sb) - 9'd1);
    assign tsh = sh >> sb;
    assign tag = TAG_W'(tsh);
    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign {q_func, q_set, q_set_raw, q_tag} = q_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (q_pop) begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= {s_func, SW'(set_raw), set_raw, tag};
        end
    end
endmodule

// File: src/sact_back.sv
// back end: set read, compare, victim choice and write back of one set
module sact_back
    import sact_pkg::*;
#(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfg_t                        cfg,
    input  logic                        q_valid,
    output logic                        q_pop,
    input  logic                        q_func,
    input  logic [$clog2(MAX_SETS)-1:0] q_set,
    input  logic [SET_OUT_W-1:0]        q_set_raw,
    input  logic [TAG_W-1:0]            q_tag,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [SET_OUT_W-1:0]        m_set_index,
    output logic [TAG_W-1:0]            m_tag_value
);
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W = TAG_W + RANK_W + 1;
    localparam int PTR_LSB = MAX_WAYS * WAY_W;
    localparam int ROW_W = PTR_LSB + WW;
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_CLR  = 2'd2;

    logic [1:0] st_reg, st_next;
    logic [SW-1:0] clr_reg;
    logic [15:0] lfsr_reg;
    logic func_reg;
    logic [SW-1:0] set_reg;
    logic [SET_OUT_W-1:0] raw_reg;
    logic [TAG_W-1:0] tag_reg;
    logic out_v_reg, out_hit_reg;
    logic [SET_OUT_W-1:0] out_set_reg;
    logic [TAG_W-1:0] out_tag_reg;

    logic [ROW_W-1:0] rdata, wdata;
    logic we;
    logic [SW-1:0] waddr;
    logic [TAG_W-1:0] tags [MAX_WAYS];
    logic [RANK_W-1:0] ranks [MAX_WAYS];
    logic [RANK_W-1:0] nranks [MAX_WAYS];
    logic [TAG_W-1:0] ntags [MAX_WAYS];
    logic [MAX_WAYS-1:0] vrow, inuse, nvld;
    logic hit, found, alloc, upd;
    logic [WW-1:0] hway, fway, lway, victim, tway, ways_m1, fptr, nptr;
    logic [RANK_W-1:0] best, old_rank;
    logic [15:0] lfsr_n;
    logic [4:0] ways;

    assign ways = (5'd1 << cfg.way_bits) > 5'(MAX_WAYS) ? 5'(MAX_WAYS)
                  : (5'd1 << cfg.way_bits);
    assign ways_m1 = WW'(ways - 5'd1);

    sact_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row (
        .aclk, .we, .waddr, .wdata,
        .re(q_pop), .raddr(q_set), .rdata
    );

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tags[w]  = rdata[w*WAY_W +: TAG_W];
            ranks[w] = rdata[w*WAY_W+TAG_W +: RANK_W];
            vrow[w]  = rdata[w*WAY_W+TAG_W+RANK_W];
            inuse[w] = (5'(w) < ways);
        end
        fptr = rdata[PTR_LSB +: WW];
        hit = 1'b0; hway = '0; found = 1'b0; fway = '0; best = '0; lway = '0;
        for (int w = MAX_WAYS-1; w >= 0; w--) begin
            if (inuse[w] && vrow[w] && tags[w] == tag_reg) begin
                hit = 1'b1; hway = WW'(w);
            end
            if (inuse[w] && !vrow[w]) begin
                found = 1'b1; fway = WW'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (inuse[w] && ranks[w] > best) begin
                best = ranks[w]; lway = WW'(w);
            end
        end
        lfsr_n = lfsr_step(lfsr_reg);
        alloc = !hit && (!func_reg || !cfg.write_through);
        upd = hit || alloc;
        if (cfg.policy == POL_FIFO) begin
            victim = fptr & ways_m1;
        end else if (found) begin
            victim = fway;
        end else if (cfg.policy == POL_LRU) begin
            victim = lway;
        end else begin
            victim = WW'(lfsr_n) & ways_m1;
        end
        nptr = fptr;
        if (alloc && cfg.policy == POL_FIFO) begin
            nptr = (victim + 1'b1) & ways_m1;
        end
        tway = hit ? hway : victim;
        old_rank = hit ? ranks[hway] : RANK_MAX;
        for (int w = 0; w < MAX_WAYS; w++) begin
            ntags[w] = (alloc && WW'(w) == victim) ? tag_reg : tags[w];
            nvld[w] = vrow[w] || (alloc && WW'(w) == victim);
            nranks[w] = ranks[w];
            if (WW'(w) == tway) begin
                nranks[w] = '0;
            end else if (inuse[w] && vrow[w] && ranks[w] < old_rank
                         && ranks[w] < RANK_MAX) begin
                nranks[w] = ranks[w] + 1'b1;
            end
            wdata[w*WAY_W +: TAG_W] = ntags[w];
            wdata[w*WAY_W+TAG_W +: RANK_W] = upd ? nranks[w] : ranks[w];
            wdata[w*WAY_W+TAG_W+RANK_W] = nvld[w];
        end
        wdata[PTR_LSB +: WW] = nptr;
        if (st_reg == ST_CLR) begin
            wdata = '0;
        end
    end

    assign we = (st_reg == ST_LOOK) || (st_reg == ST_CLR);
    assign waddr = (st_reg == ST_CLR) ? clr_reg : set_reg;
    assign q_pop = (st_reg == ST_IDLE) && q_valid && (!out_v_reg || m_ready);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_CLR:  st_next = (clr_reg == SW'(MAX_SETS-1)) ? ST_IDLE : ST_CLR;
            ST_IDLE: st_next = q_pop ? ST_LOOK : ST_IDLE;
            ST_LOOK: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            clr_reg <= '0;
            lfsr_reg <= LFSR_RESET;
            out_v_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == ST_CLR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            if (st_reg == ST_LOOK) begin
                out_v_reg <= 1'b1;
                if (alloc && cfg.policy != POL_FIFO && !found && cfg.policy != POL_LRU) begin
                    lfsr_reg <= lfsr_n;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            func_reg <= q_func; set_reg <= q_set; raw_reg <= q_set_raw; tag_reg <= q_tag;
        end
        if (st_reg == ST_LOOK) begin
            out_hit_reg <= hit; out_set_reg <= raw_reg; out_tag_reg <= tag_reg;
        end
    end

    assign m_valid = out_v_reg;
    assign m_hit = out_hit_reg;
    assign m_set_index = out_set_reg;
    assign m_tag_value = out_tag_reg;
endmodule

// File: src/set_assoc_cache_tag_lookup.sv
// Set-associative cache tag lookup. The back end pops an access and reads its set in
// idle, then compares and writes back that set in look; it pops the next only in idle,
// with the output free or being taken. The front end queues up to two accesses. After
// reset a clearing pass zeroes the row memory (tags, ranks, valid bits and fifo
// pointers) before the first access is looked up. Configuration writes are taken at any
// time but belong between accesses, with nothing in flight.
module set_assoc_cache_tag_lookup
    import sact_pkg::*;
#(
    parameter int MAX_SETS   = MAX_SETS_DEF,
    parameter int MAX_WAYS   = MAX_WAYS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [3:0]            cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_func,
    input  logic [ADDR_WIDTH-1:0] s_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [SET_OUT_W-1:0]  m_set_index,
    output logic [TAG_W-1:0]      m_tag_value
);
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    cfg_t cfg_reg;
    logic q_valid, q_pop, q_func;
    logic [SW-1:0] q_set;
    logic [SET_OUT_W-1:0] q_set_raw;
    logic [TAG_W-1:0] q_tag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{way_bits: 2'd0, set_bits: 4'd0, offset_bits: 4'd4,
                         policy: POL_FIFO, write_through: 1'b0};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WAY_BITS:    cfg_reg.way_bits <= cfg_data[1:0];
                CFG_SET_BITS:    cfg_reg.set_bits <= cfg_data;
                CFG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data;
                CFG_POLICY:      cfg_reg.policy <= cfg_data[1:0];
                CFG_WT:          cfg_reg.write_through <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sact_front #(.MAX_SETS(MAX_SETS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .aclk, .aresetn, .cfg(cfg_reg), .s_valid, .s_ready, .s_func, .s_address,
        .q_valid, .q_pop, .q_func, .q_set, .q_set_raw, .q_tag
    );

    sact_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
        .aclk, .aresetn, .cfg(cfg_reg), .q_valid, .q_pop, .q_func, .q_set,
        .q_set_raw, .q_tag, .m_valid, .m_ready, .m_hit, .m_set_index, .m_tag_value
    );
endmodule

// File: src/sact_checker.sv
// port checker for the cache tag lookup, bound to the top level
module sact_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_hit,
    input logic [31:0] m_tag_value
);
    a_mhold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_value) && $stable(m_hit))
        else $error("result changed while stalled");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result after reset");
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("results closer than two cycles");
    a_sready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");
    a_shold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid dropped before transfer");
endmodule

bind set_assoc_cache_tag_lookup sact_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_hit, .m_tag_value
);
